FILE: rtl/arx_permutation_512_unit_defines.svh
// assertion macros shared by the permutation unit rtl
// expects clk and arst_n in scope of the module that uses them
`ifndef ARX_PERMUTATION_512_UNIT_DEFINES_SVH
`define ARX_PERMUTATION_512_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ARXP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ARXP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/arxp_pkg.sv
// types, rotation tables and word helpers for the 512-bit arx permutation
// no dependencies
package arxp_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] state_t;

	typedef struct packed {
		logic vld;
		logic inv;
	} ctl_t;

	localparam int NUM_STEPS = 3;
	localparam int NUM_LANES = 4;

	// row rotations per mix step, for rows b, c and d
	localparam int ROT_B [NUM_STEPS] = '{1, 4, 8};
	localparam int ROT_C [NUM_STEPS] = '{2, 8, 12};
	localparam int ROT_D [NUM_STEPS] = '{3, 12, 16};

	function automatic word_t rotl(word_t x, int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// lane shuffle of rows b, c and d, its own inverse
	function automatic state_t shuffle(state_t s);
		state_t t;
		t = s;
		t[5] = s[7];
		t[7] = s[5];
		t[8] = s[9];
		t[9] = s[8];
		t[10] = s[11];
		t[11] = s[10];
		t[12] = s[14];
		t[14] = s[12];
		return t;
	endfunction

endpackage

FILE: rtl/arxp_lane.sv
// one column lane: add-xor mix with row rotations, or its inverse
// depends on arxp_pkg
module arxp_lane #(
	parameter int RB_F = 1,
	parameter int RC_F = 2,
	parameter int RD_F = 3,
	parameter int RB_I = 8,
	parameter int RC_I = 12,
	parameter int RD_I = 16
) (
	input  logic           inv,
	input  arxp_pkg::word_t a,
	input  arxp_pkg::word_t b,
	input  arxp_pkg::word_t c,
	input  arxp_pkg::word_t d,
	output arxp_pkg::word_t a_out,
	output arxp_pkg::word_t b_out,
	output arxp_pkg::word_t c_out,
	output arxp_pkg::word_t d_out
);
	import arxp_pkg::*;

	word_t fa, fb, fc, fd;
	word_t rb, rc, rd;
	word_t ia, ib, ic, id;

	// forward: add, xor, then rotate
	always_comb begin
		fa = a + b;
		fc = c + d;
		fb = b ^ fc;
		fd = d ^ fa;
	end

	// inverse: rotate back, xor, then subtract
	always_comb begin
		rb = rotr(b, RB_I);
		rc = rotr(c, RC_I);
		rd = rotr(d, RD_I);
		id = rd ^ a;
		ib = rb ^ rc;
		ic = rc - id;
		ia = a - ib;
	end

	always_comb begin
		if (inv) begin
			a_out = ia;
			b_out = ib;
			c_out = ic;
			d_out = id;
		end else begin
			a_out = fa;
			b_out = rotl(fb, RB_F);
			c_out = rotl(fc, RC_F);
			d_out = rotl(fd, RD_F);
		end
	end

endmodule

FILE: rtl/arxp_stage.sv
// one pipeline stage: four column lanes, round constant and lane shuffle merge
// depends on arxp_pkg and arxp_lane
module arxp_stage #(
	parameter int STEP   = 0,
	parameter int RC_FWD = 1,
	parameter int RC_INV = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  arxp_pkg::ctl_t   ctl_in,
	input  arxp_pkg::state_t st_in,
	output arxp_pkg::ctl_t   ctl_out,
	output arxp_pkg::state_t st_out
);
	import arxp_pkg::*;

	localparam word_t KF = word_t'(RC_FWD);
	localparam word_t KI = word_t'(RC_INV);

	state_t pre, mid, post;
	ctl_t   ctl_s1;
	state_t st_s1;

	// round entry: forward xors the round number, inverse undoes the shuffle
	always_comb begin
		pre = st_in;
		if (STEP == 0) begin
			if (ctl_in.inv) begin
				pre = shuffle(st_in);
			end else begin
				pre[0] = st_in[0] ^ KF;
			end
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		arxp_lane #(
			.RB_F(ROT_B[STEP]),
			.RC_F(ROT_C[STEP]),
			.RD_F(ROT_D[STEP]),
			.RB_I(ROT_B[NUM_STEPS - 1 - STEP]),
			.RC_I(ROT_C[NUM_STEPS - 1 - STEP]),
			.RD_I(ROT_D[NUM_STEPS - 1 - STEP])
		) u_lane (
			.inv  (ctl_in.inv),
			.a    (pre[l]),
			.b    (pre[4 + l]),
			.c    (pre[8 + l]),
			.d    (pre[12 + l]),
			.a_out(mid[l]),
			.b_out(mid[4 + l]),
			.c_out(mid[8 + l]),
			.d_out(mid[12 + l])
		);
	end

	// round exit: forward shuffles lanes, inverse removes the round number
	always_comb begin
		post = mid;
		if (STEP == NUM_STEPS - 1) begin
			if (ctl_in.inv) begin
				post[0] = mid[0] ^ KI;
			end else begin
				post = shuffle(mid);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= post;
		end
	end

	assign ctl_out = ctl_s1;
	assign st_out  = st_s1;

endmodule

FILE: rtl/arx_permutation_512_unit.sv
// Fully unrolled 512-bit ARX permutation. Each round is three pipeline stages,
// one column mix per stage, with the four columns computed by parallel lanes and
// the round constant and lane shuffle merged at the round edges. One state per
// cycle is taken while no result is stalled at the output, forward or inverse
// mixed freely. The whole pipeline holds while a result is offered and not
// taken; req_ready then drops in the same cycle.
// depends on arxp_pkg, arxp_stage and the assertion macro header
`include "arx_permutation_512_unit_defines.svh"

module arx_permutation_512_unit #(
	parameter int ROUND_COUNT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        cmd,
	input  logic [63:0] words_in_0,
	input  logic [63:0] words_in_1,
	input  logic [63:0] words_in_2,
	input  logic [63:0] words_in_3,
	input  logic [63:0] words_in_4,
	input  logic [63:0] words_in_5,
	input  logic [63:0] words_in_6,
	input  logic [63:0] words_in_7,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [63:0] words_out_0,
	output logic [63:0] words_out_1,
	output logic [63:0] words_out_2,
	output logic [63:0] words_out_3,
	output logic [63:0] words_out_4,
	output logic [63:0] words_out_5,
	output logic [63:0] words_out_6,
	output logic [63:0] words_out_7
);
	import arxp_pkg::*;

	localparam int DEPTH = NUM_STEPS * ROUND_COUNT;

	state_t stage_st  [DEPTH + 1];
	ctl_t   stage_ctl [DEPTH + 1];
	logic   en;

	assign en = !(stage_ctl[DEPTH].vld && !rsp_ready);
	assign req_ready = en;

	assign stage_ctl[0].vld = req_valid;
	assign stage_ctl[0].inv = cmd;
	assign stage_st[0] = {words_in_7, words_in_6, words_in_5, words_in_4,
		words_in_3, words_in_2, words_in_1, words_in_0};

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		arxp_stage #(
			.STEP  (k % NUM_STEPS),
			.RC_FWD(k / NUM_STEPS + 1),
			.RC_INV(ROUND_COUNT - k / NUM_STEPS)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (stage_ctl[k]),
			.st_in  (stage_st[k]),
			.ctl_out(stage_ctl[k + 1]),
			.st_out (stage_st[k + 1])
		);
	end

	assign rsp_valid = stage_ctl[DEPTH].vld;
	assign {words_out_7, words_out_6, words_out_5, words_out_4,
		words_out_3, words_out_2, words_out_1, words_out_0} = stage_st[DEPTH];

	// a transaction taken on the request side enters the first stage with its command
	`ARXP_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, stage_ctl[1].vld && (stage_ctl[1].inv == $past(cmd)), "accepted transaction missing from first stage")
	// a held pipeline keeps the first and last stages in place
	`ARXP_ASSERT_NEXT(a_stall_holds, !en, $stable(stage_ctl[1]) && $stable(stage_ctl[DEPTH]), "pipeline moved while stalled")
	// a bubble in the last stage but one leaves no result behind after a move
	`ARXP_ASSERT_NEXT(a_bubble_out, en && !stage_ctl[DEPTH - 1].vld, !rsp_valid, "result appeared from an empty stage")
	// ready only drops while a result waits at the output
	`ARXP_ASSERT_NOW(a_ready_cause, !req_ready, rsp_valid, "request side stalled with no pending result")

endmodule

FILE: sim/arx_permutation_512_unit_tb.sv
// self-checking testbench for arx_permutation_512_unit, forward and inverse 512-bit permutation
// depends on arxp_pkg (state_t) and the unit rtl; results are predicted in the bench itself
module arx_permutation_512_unit_tb;
	import arxp_pkg::state_t;

	localparam int ROUNDS = 12;
	localparam int LATENCY = 3 * ROUNDS;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 160;
	localparam int NUM_PHASES = 4;
	localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 74, 0, 27};
	localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 74, 27};
	// rotation amounts of rows b, c and d after each of the three mixes
	localparam int ROW_ROT [3][3] = '{'{1, 2, 3}, '{4, 8, 12}, '{8, 12, 16}};

	localparam bit CMD_FORWARD = 1'b0;
	localparam bit CMD_INVERSE = 1'b1;

	// directed row: each 64-bit port gets fill where its sel bit is set, zero elsewhere
	typedef struct packed {
		logic        inv;
		logic [63:0] fill;
		logic [7:0]  sel;
	} pattern_t;

	localparam int NUM_DIRECTED = 20;
	localparam pattern_t DIRECTED [NUM_DIRECTED] = '{
		'{CMD_FORWARD, 64'h0000000000000000, 8'h00},
		'{CMD_INVERSE, 64'h0000000000000000, 8'h00},
		'{CMD_FORWARD, 64'hFFFFFFFFFFFFFFFF, 8'hFF},
		'{CMD_INVERSE, 64'hFFFFFFFFFFFFFFFF, 8'hFF},
		'{CMD_FORWARD, 64'h0000000000000001, 8'h01},
		'{CMD_INVERSE, 64'h0000000000000001, 8'h01},
		'{CMD_FORWARD, 64'h000000000000000C, 8'h01},
		'{CMD_INVERSE, 64'h000000000000000C, 8'h01},
		'{CMD_FORWARD, 64'h8000000080000000, 8'hFF},
		'{CMD_INVERSE, 64'h8000000080000000, 8'hFF},
		'{CMD_FORWARD, 64'h5555555555555555, 8'hFF},
		'{CMD_INVERSE, 64'hAAAAAAAAAAAAAAAA, 8'hFF},
		'{CMD_FORWARD, 64'hFFFFFFFF00000000, 8'hFF},
		'{CMD_INVERSE, 64'h00000000FFFFFFFF, 8'hFF},
		'{CMD_FORWARD, 64'hFFFFFFFFFFFFFFFF, 8'h03},
		'{CMD_INVERSE, 64'hFFFFFFFFFFFFFFFF, 8'h0C},
		'{CMD_FORWARD, 64'hFFFFFFFFFFFFFFFF, 8'h30},
		'{CMD_INVERSE, 64'hFFFFFFFFFFFFFFFF, 8'hC0},
		'{CMD_FORWARD, 64'h7FFFFFFF7FFFFFFF, 8'hAA},
		'{CMD_INVERSE, 64'h0123456789ABCDEF, 8'h5A}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        cmd = CMD_FORWARD;
	state_t      req_words = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [63:0] words_out_0, words_out_1, words_out_2, words_out_3;
	logic [63:0] words_out_4, words_out_5, words_out_6, words_out_7;
	state_t      rsp_words;

	state_t      pending_perms [$];
	state_t      want;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;
	int          num_sent = 0;
	int          num_inverse = 0;
	int          num_results = 0;
	int          num_roundtrips = 0;
	int          num_errors = 0;

	assign rsp_words = {words_out_7, words_out_6, words_out_5, words_out_4,
		words_out_3, words_out_2, words_out_1, words_out_0};

	arx_permutation_512_unit #(.ROUND_COUNT(ROUNDS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.words_in_0 (req_words[1:0]),
		.words_in_1 (req_words[3:2]),
		.words_in_2 (req_words[5:4]),
		.words_in_3 (req_words[7:6]),
		.words_in_4 (req_words[9:8]),
		.words_in_5 (req_words[11:10]),
		.words_in_6 (req_words[13:12]),
		.words_in_7 (req_words[15:14]),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.words_out_0(words_out_0),
		.words_out_1(words_out_1),
		.words_out_2(words_out_2),
		.words_out_3(words_out_3),
		.words_out_4(words_out_4),
		.words_out_5(words_out_5),
		.words_out_6(words_out_6),
		.words_out_7(words_out_7)
	);

	function automatic logic [31:0] rot_left(logic [31:0] x, int n);
		logic [63:0] twice;
		twice = {x, x};
		return twice[63 - n -: 32];
	endfunction

	// swaps b1/b3, c0/c1, c2/c3 and d0/d2
	function automatic state_t lane_swap(state_t s);
		state_t t;
		t = s;
		t[5] = s[7];
		t[7] = s[5];
		t[8] = s[9];
		t[9] = s[8];
		t[10] = s[11];
		t[11] = s[10];
		t[12] = s[14];
		t[14] = s[12];
		return t;
	endfunction

	function automatic state_t arx_permute(logic inv, state_t st);
		state_t s;
		s = st;
		if (inv == CMD_FORWARD) begin
			for (int r = 1; r <= ROUNDS; r++) begin
				s[0] = s[0] ^ 32'(r);
				for (int j = 0; j < 3; j++) begin
					// each lane only touches its own column, so mix and rotate per lane
					for (int l = 0; l < 4; l++) begin
						s[l] = s[l] + s[4 + l];
						s[8 + l] = s[8 + l] + s[12 + l];
						s[4 + l] = s[4 + l] ^ s[8 + l];
						s[12 + l] = s[12 + l] ^ s[l];
						s[4 + l] = rot_left(s[4 + l], ROW_ROT[j][0]);
						s[8 + l] = rot_left(s[8 + l], ROW_ROT[j][1]);
						s[12 + l] = rot_left(s[12 + l], ROW_ROT[j][2]);
					end
				end
				s = lane_swap(s);
			end
		end else begin
			for (int r = ROUNDS; r >= 1; r--) begin
				s = lane_swap(s);
				for (int j = 2; j >= 0; j--) begin
					for (int l = 0; l < 4; l++) begin
						s[4 + l] = rot_left(s[4 + l], 32 - ROW_ROT[j][0]);
						s[8 + l] = rot_left(s[8 + l], 32 - ROW_ROT[j][1]);
						s[12 + l] = rot_left(s[12 + l], 32 - ROW_ROT[j][2]);
						s[12 + l] = s[12 + l] ^ s[l];
						s[4 + l] = s[4 + l] ^ s[8 + l];
						s[8 + l] = s[8 + l] - s[12 + l];
						s[l] = s[l] - s[4 + l];
					end
				end
				s[0] = s[0] ^ 32'(r);
			end
		end
		return s;
	endfunction

	// mix of dense random, zero, all-ones, single-bit and single-zero words to hit carry corners
	function automatic state_t random_state();
		state_t s;
		for (int w = 0; w < 16; w++) begin
			case ($urandom_range(0, 5))
				0: s[w] = '0;
				1: s[w] = '1;
				2: s[w] = 32'd1 << $urandom_range(0, 31);
				3: s[w] = ~(32'd1 << $urandom_range(0, 31));
				default: s[w] = $urandom;
			endcase
		end
		return s;
	endfunction

	task automatic send_state(logic inv, state_t st);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= inv;
		req_words <= st;
		do @(posedge clk); while (!req_ready);
	endtask

	// hold the request side until every pending result is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		// let the scoreboard log the last accepted transaction first
		@(posedge clk);
		while (pending_perms.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				pending_perms.push_back(arx_permute(cmd, req_words));
				num_sent++;
				if (cmd == CMD_INVERSE)
					num_inverse++;
			end
			if (rsp_valid && rsp_ready) begin
				num_results++;
				if (pending_perms.size() == 0) begin
					$error("result transaction with no request pending");
					num_errors++;
				end else begin
					want = pending_perms.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (rsp_words[2 * k + 1 -: 2] !== want[2 * k + 1 -: 2]) begin
							$error("words_out_%0d: expected %h, got %h", k,
								want[2 * k + 1 -: 2], rsp_words[2 * k + 1 -: 2]);
							num_errors++;
						end
					end
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no transaction for %0d cycles, %0d results pending",
					quiet_cycles, pending_perms.size());
				$display("arx_permutation_512_unit_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		state_t st;
		state_t prev_st;
		logic   c;
		logic   prev_c;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			for (int k = 0; k < 8; k++)
				st[2 * k + 1 -: 2] = DIRECTED[i].sel[k] ? DIRECTED[i].fill : 64'd0;
			send_state(DIRECTED[i].inv, st);
		end
		wait_drained();

		prev_st = random_state();
		prev_c = CMD_FORWARD;
		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// now and then feed the previous output back the other way round
				if ($urandom_range(0, 5) == 0) begin
					st = arx_permute(prev_c, prev_st);
					c = ~prev_c;
					num_roundtrips++;
				end else begin
					st = random_state();
					c = 1'($urandom_range(0, 1));
				end
				send_state(c, st);
				prev_st = st;
				prev_c = c;
			end
			wait_drained();
		end

		// catch any stray result after the last expected one
		repeat (LATENCY + 20) @(posedge clk);

		$display("%0d states permuted (%0d inverse, %0d fed back from a previous output)",
			num_sent, num_inverse, num_roundtrips);
		$display("%0d results compared over 4 flow-control mixes, %0d mismatches",
			num_results, num_errors);
		if (num_errors == 0 && pending_perms.size() == 0)
			$display("arx_permutation_512_unit_tb OK");
		else
			$display("arx_permutation_512_unit_tb NOT OK");
		$finish;
	end

endmodule
